/* rtl/core/wsvn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsvn_pkg
// Types, constants and helpers shared by the welded vertex normal block.
// ----------------------------------------------------------------------------
package wsvn_pkg;

  localparam int MAX_VERTICES  = 1024;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = IDX_W + 1;
  localparam int POSITION_BITS = 24;
  localparam int FB_W          = 16;
  localparam int DIFF_W        = POSITION_BITS + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int CROSS_W       = PROD_W + 1;
  localparam int SUM_W         = 64;
  localparam int NRM_W         = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SRC_SUM  = 2'd0,
    SRC_FB   = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_NONE = 2'd3
  } source_t;

  typedef struct packed {
    logic [1:0]                      opcode;
    logic [IDX_W-1:0]                vertex_index;
    logic [IDX_W-1:0]                corner_a;
    logic [IDX_W-1:0]                corner_b;
    logic [IDX_W-1:0]                corner_c;
    logic signed [POSITION_BITS-1:0] pos_x;
    logic signed [POSITION_BITS-1:0] pos_y;
    logic signed [POSITION_BITS-1:0] pos_z;
    logic signed [FB_W-1:0]          fallback_x;
    logic signed [FB_W-1:0]          fallback_y;
    logic signed [FB_W-1:0]          fallback_z;
    logic                            has_fallback;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        queried_index;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [1:0]              source;
  } out_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos_x;
    logic [POSITION_BITS-1:0] pos_y;
    logic [POSITION_BITS-1:0] pos_z;
    logic signed [FB_W-1:0]   fb_x;
    logic signed [FB_W-1:0]   fb_y;
    logic signed [FB_W-1:0]   fb_z;
    logic                     has_fb;
    logic [IDX_W-1:0]         group;
  } vrec_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sums_t;

  typedef struct packed {
    logic                    done;
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } norm_res_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   a,
    input logic signed [CROSS_W-1:0] b
  );
    logic signed [SUM_W:0] t;
    t = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W+1-CROSS_W){b[CROSS_W-1]}}, b});
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

/* rtl/core/wsvn_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsvn_norm
// Scales a group sum into range, takes the integer root of its squared length
// and divides each component bit by bit into a Q1.15 unit normal.
// ----------------------------------------------------------------------------
module wsvn_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  wsvn_pkg::sums_t     sum_in,
  output wsvn_pkg::norm_res_t res
);
  import wsvn_pkg::*;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_ROOT  = 6'b001000,
    N_LEN   = 6'b010000,
    N_DIV   = 6'b100000
  } nstate_t;

  localparam logic signed [SUM_W-1:0] LIM_P = SUM_W'(64'sd1073741824);
  localparam logic signed [SUM_W-1:0] LIM_N = -LIM_P;

  nstate_t                 state_r, state_nxt;
  logic signed [SUM_W-1:0] s_r [3];
  logic [61:0]             prod_r;
  logic [63:0]             sq_r, rem_r, root_r, bit_r;
  logic [1:0]              k_r;
  logic [4:0]              cnt_r;
  logic [30:0]             len_r;
  logic [31:0]             dr_r;
  logic [15:0]             q_r;
  logic signed [NRM_W-1:0] nrm_r [3];
  logic                    done_r;

  logic                    any_big;
  logic signed [30:0]      sl;
  logic signed [61:0]      sqp;
  logic [63:0]             rt;
  logic                    ge;
  logic [15:0]             qf, qc;
  logic signed [SUM_W-1:0] s_cur, s_next;

  function automatic logic big(input logic signed [SUM_W-1:0] v);
    return (v >= LIM_P) || (v <= LIM_N);
  endfunction

  function automatic logic [31:0] mag(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] a;
    a = v[SUM_W-1] ? -v : v;
    return a[31:0];
  endfunction

  assign any_big = big(s_r[0]) || big(s_r[1]) || big(s_r[2]);

  always_comb begin
    unique case (k_r)
      2'd0:    begin s_cur = s_r[0]; s_next = s_r[1]; end
      2'd1:    begin s_cur = s_r[1]; s_next = s_r[2]; end
      default: begin s_cur = s_r[2]; s_next = s_r[2]; end
    endcase
  end

  assign sl  = s_cur[30:0];
  assign sqp = sl * sl;
  assign rt  = root_r + bit_r;
  assign ge  = dr_r >= {1'b0, len_r};
  assign qf  = {q_r[14:0], ge};
  assign qc  = (qf > 16'd32767) ? 16'd32767 : qf;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:  if (start) state_nxt = N_SHIFT;
      N_SHIFT: if (!any_big) state_nxt = N_SQ;
      N_SQ:    if (k_r == 2'd3) state_nxt = N_ROOT;
      N_ROOT:  if (cnt_r == 5'd31) state_nxt = N_LEN;
      N_LEN:   state_nxt = N_DIV;
      N_DIV:   if (cnt_r == 5'd15 && k_r == 2'd2) state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == N_DIV) && (cnt_r == 5'd15) && (k_r == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      N_IDLE: begin
        s_r[0] <= sum_in.x;
        s_r[1] <= sum_in.y;
        s_r[2] <= sum_in.z;
      end
      N_SHIFT: begin
        if (any_big) begin
          s_r[0] <= s_r[0] >>> 1;
          s_r[1] <= s_r[1] >>> 1;
          s_r[2] <= s_r[2] >>> 1;
        end else begin
          k_r  <= 2'd0;
          sq_r <= '0;
        end
      end
      N_SQ: begin
        prod_r <= sqp;
        if (k_r != 2'd0) sq_r <= sq_r + {2'b00, prod_r};
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          rem_r  <= sq_r + {2'b00, prod_r};
          root_r <= '0;
          bit_r  <= 64'd1 << 62;
          cnt_r  <= '0;
        end
      end
      N_ROOT: begin
        if (rem_r >= rt) begin
          rem_r  <= rem_r - rt;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
      end
      N_LEN: begin
        len_r <= (root_r == '0) ? 31'd1 : root_r[30:0];
        k_r   <= 2'd0;
        cnt_r <= '0;
        q_r   <= '0;
        dr_r  <= mag(s_r[0]);
      end
      N_DIV: begin
        q_r   <= qf;
        dr_r  <= ge ? ((dr_r - {1'b0, len_r}) << 1) : (dr_r << 1);
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          nrm_r[k_r] <= s_cur[SUM_W-1] ? -$signed(qc) : $signed(qc);
          k_r   <= k_r + 2'd1;
          cnt_r <= '0;
          q_r   <= '0;
          dr_r  <= mag(s_next);
        end
      end
      default: ;
    endcase
  end

  assign res.done = done_r;
  assign res.x    = nrm_r[0];
  assign res.y    = nrm_r[1];
  assign res.z    = nrm_r[2];

endmodule

/* rtl/core/welded_smooth_vertex_normals.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// welded_smooth_vertex_normals
// Welded, area-weighted smooth vertex normals over a vertex store and a group
// sum store.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A load probes the earlier vertices in
// the vertex memory in order, a read and then a compare for each, until one
// has the same position or the last has been probed; it also zeroes the group
// sum at the new vertex's own index, so no clearing pass is needed after
// reset or clear. A triangle takes three vertex reads, six products on one
// multiplier, then three read-modify-write passes on the sum memory. A query
// with a nonzero group sum runs the range shift (up to 34 steps), the 32-step
// integer root and three 16-step divisions. A finished result waits in the
// output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module welded_smooth_vertex_normals (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wsvn_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output wsvn_pkg::out_t out_data
);
  import wsvn_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_LD_PRB = 15'b000000000000010,
    S_LD_CMP = 15'b000000000000100,
    S_LD_WR  = 15'b000000000001000,
    S_TR_RD  = 15'b000000000010000,
    S_TR_CAP = 15'b000000000100000,
    S_TR_DIF = 15'b000000001000000,
    S_TR_MUL = 15'b000000010000000,
    S_SM_RD  = 15'b000000100000000,
    S_SM_WR  = 15'b000001000000000,
    S_Q_RD   = 15'b000010000000000,
    S_Q_GRP  = 15'b000100000000000,
    S_Q_SUM  = 15'b001000000000000,
    S_Q_NRM  = 15'b010000000000000,
    S_Q_OUT  = 15'b100000000000000
  } state_t;

  state_t                   state_r, state_nxt;
  in_t                      in_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         j_r, gnew_r;
  logic [1:0]               k_r;
  logic [2:0]               m_r;
  logic [POSITION_BITS-1:0] pos_r [3][3];
  logic [IDX_W-1:0]         grp_r [3];
  logic signed [DIFF_W-1:0] d1_r [3];
  logic signed [DIFF_W-1:0] d2_r [3];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CROSS_W-1:0] cr_r [3];
  vrec_t                    qrec_r;
  out_t                     res_r, out_r;
  logic                     out_valid_r;

  vrec_t                    vmem [MAX_VERTICES];
  vrec_t                    vrd_r, vwdata;
  logic [IDX_W-1:0]         vaddr, corner_sel;
  logic                     vwe;
  sums_t                    smem [MAX_VERTICES];
  sums_t                    srd_r, swdata;
  logic [IDX_W-1:0]         saddr, swaddr;
  logic                     swe;

  logic                     in_acc, out_free, pos_match, probe_last, tri_ok, q_miss;
  logic signed [DIFF_W-1:0] ma, mb;
  logic [2:0]               pm1;
  logic [1:0]               axis;
  logic signed [CROSS_W-1:0] pext;
  logic                     nrm_start;
  norm_res_t                nrm_res;

  function automatic logic signed [FB_W-1:0] clamp_fb(input logic signed [FB_W-1:0] v);
    return (v == {1'b1, {(FB_W-1){1'b0}}}) ? -$signed({1'b0, {(FB_W-1){1'b1}}}) : v;
  endfunction

  function automatic logic signed [DIFF_W-1:0] pdiff(
    input logic [POSITION_BITS-1:0] a,
    input logic [POSITION_BITS-1:0] b
  );
    return $signed({a[POSITION_BITS-1], a}) - $signed({b[POSITION_BITS-1], b});
  endfunction

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign pos_match  = (vrd_r.pos_x == in_r.pos_x) && (vrd_r.pos_y == in_r.pos_y) &&
                      (vrd_r.pos_z == in_r.pos_z);
  assign probe_last = ({1'b0, j_r} + CNT_W'(1)) == cnt_r;
  assign tri_ok     = ({1'b0, in_data.corner_a} < cnt_r) && ({1'b0, in_data.corner_b} < cnt_r) &&
                      ({1'b0, in_data.corner_c} < cnt_r);
  assign q_miss     = {1'b0, in_data.vertex_index} >= cnt_r;
  assign nrm_start  = (state_r == S_Q_SUM) && (srd_r != '0);

  always_comb begin
    unique case (k_r)
      2'd0:    corner_sel = in_r.corner_a;
      2'd1:    corner_sel = in_r.corner_b;
      default: corner_sel = in_r.corner_c;
    endcase
  end

  always_comb begin
    vaddr = in_r.vertex_index;
    if (state_r == S_LD_PRB) vaddr = j_r;
    else if (state_r == S_TR_RD) vaddr = corner_sel;
  end

  assign saddr  = (state_r == S_SM_RD) ? grp_r[k_r] : vrd_r.group;
  assign vwe    = (state_r == S_LD_WR);
  assign swe    = (state_r == S_LD_WR) || (state_r == S_SM_WR);
  assign swaddr = (state_r == S_LD_WR) ? cnt_r[IDX_W-1:0] : grp_r[k_r];

  always_comb begin
    vwdata.pos_x  = in_r.pos_x;
    vwdata.pos_y  = in_r.pos_y;
    vwdata.pos_z  = in_r.pos_z;
    vwdata.fb_x   = in_r.fallback_x;
    vwdata.fb_y   = in_r.fallback_y;
    vwdata.fb_z   = in_r.fallback_z;
    vwdata.has_fb = in_r.has_fallback;
    vwdata.group  = gnew_r;
  end

  always_comb begin
    if (state_r == S_LD_WR) begin
      swdata = '0;
    end else begin
      swdata.x = sat_add(srd_r.x, cr_r[0]);
      swdata.y = sat_add(srd_r.y, cr_r[1]);
      swdata.z = sat_add(srd_r.z, cr_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[cnt_r[IDX_W-1:0]] <= vwdata;
    vrd_r <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= swdata;
    srd_r <= smem[saddr];
  end

  always_comb begin
    unique case (m_r)
      3'd0:    begin ma = d1_r[1]; mb = d2_r[2]; end
      3'd1:    begin ma = d1_r[2]; mb = d2_r[1]; end
      3'd2:    begin ma = d1_r[2]; mb = d2_r[0]; end
      3'd3:    begin ma = d1_r[0]; mb = d2_r[2]; end
      3'd4:    begin ma = d1_r[0]; mb = d2_r[1]; end
      3'd5:    begin ma = d1_r[1]; mb = d2_r[0]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign pm1  = m_r - 3'd1;
  assign axis = pm1[2:1];
  assign pext = $signed({prod_r[PROD_W-1], prod_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (opcode_t'(in_data.opcode))
            OP_LOAD: begin
              if (cnt_r == CNT_W'(MAX_VERTICES)) state_nxt = S_IDLE;
              else if (cnt_r == '0) state_nxt = S_LD_WR;
              else state_nxt = S_LD_PRB;
            end
            OP_TRI:   state_nxt = tri_ok ? S_TR_RD : S_IDLE;
            OP_QUERY: state_nxt = q_miss ? S_Q_OUT : S_Q_RD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_PRB: state_nxt = S_LD_CMP;
      S_LD_CMP: state_nxt = (pos_match || probe_last) ? S_LD_WR : S_LD_PRB;
      S_LD_WR:  state_nxt = S_IDLE;
      S_TR_RD:  state_nxt = S_TR_CAP;
      S_TR_CAP: state_nxt = (k_r == 2'd2) ? S_TR_DIF : S_TR_RD;
      S_TR_DIF: state_nxt = S_TR_MUL;
      S_TR_MUL: if (m_r == 3'd6) state_nxt = S_SM_RD;
      S_SM_RD:  state_nxt = S_SM_WR;
      S_SM_WR:  state_nxt = (k_r == 2'd2) ? S_IDLE : S_SM_RD;
      S_Q_RD:   state_nxt = S_Q_GRP;
      S_Q_GRP:  state_nxt = S_Q_SUM;
      S_Q_SUM:  state_nxt = (srd_r == '0) ? S_Q_OUT : S_Q_NRM;
      S_Q_NRM:  if (nrm_res.done) state_nxt = S_Q_OUT;
      S_Q_OUT:  if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LD_WR) cnt_r <= cnt_r + CNT_W'(1);
      if (in_acc && opcode_t'(in_data.opcode) == OP_CLEAR) cnt_r <= '0;
      if (state_r == S_Q_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_Q_OUT && out_free) out_r <= res_r;
    unique case (state_r)
      S_IDLE: begin
        in_r   <= in_data;
        j_r    <= '0;
        k_r    <= '0;
        gnew_r <= cnt_r[IDX_W-1:0];
        res_r.queried_index <= in_data.vertex_index;
        res_r.normal_x      <= '0;
        res_r.normal_y      <= '0;
        res_r.normal_z      <= '0;
        res_r.source        <= SRC_NONE;
      end
      S_LD_CMP: begin
        if (pos_match) gnew_r <= j_r;
        else j_r <= j_r + IDX_W'(1);
      end
      S_TR_CAP: begin
        pos_r[k_r][0] <= vrd_r.pos_x;
        pos_r[k_r][1] <= vrd_r.pos_y;
        pos_r[k_r][2] <= vrd_r.pos_z;
        grp_r[k_r]    <= vrd_r.group;
        k_r           <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      S_TR_DIF: begin
        for (int i = 0; i < 3; i++) begin
          d1_r[i] <= pdiff(pos_r[1][i], pos_r[0][i]);
          d2_r[i] <= pdiff(pos_r[2][i], pos_r[0][i]);
        end
        m_r <= '0;
      end
      S_TR_MUL: begin
        prod_r <= ma * mb;
        m_r    <= m_r + 3'd1;
        if (m_r != 3'd0) begin
          if (pm1[0]) cr_r[axis] <= cr_r[axis] - pext;
          else cr_r[axis] <= pext;
        end
      end
      S_SM_WR: k_r <= k_r + 2'd1;
      S_Q_GRP: qrec_r <= vrd_r;
      S_Q_SUM: begin
        if (srd_r == '0) begin
          res_r.source   <= qrec_r.has_fb ? SRC_FB : SRC_ZERO;
          res_r.normal_x <= qrec_r.has_fb ? clamp_fb(qrec_r.fb_x) : '0;
          res_r.normal_y <= qrec_r.has_fb ? clamp_fb(qrec_r.fb_y) : '0;
          res_r.normal_z <= qrec_r.has_fb ? clamp_fb(qrec_r.fb_z) : '0;
        end
      end
      S_Q_NRM: begin
        if (nrm_res.done) begin
          res_r.source   <= SRC_SUM;
          res_r.normal_x <= nrm_res.x;
          res_r.normal_y <= nrm_res.y;
          res_r.normal_z <= nrm_res.z;
        end
      end
      default: ;
    endcase
  end

  wsvn_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (nrm_start),
    .sum_in (srd_r),
    .res    (nrm_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count past store depth");

  a_load_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD_WR) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("load did not advance vertex count");

  a_norm_owner: assert property (@(posedge clk) disable iff (!rst_n)
    nrm_res.done |-> (state_r == S_Q_NRM))
    else $error("normalizer finished outside a query");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_Q_OUT))
    else $error("result raised outside output state");

endmodule
